// ===== sv/huffman_code_bit_packer_core_defines.svh =====
// ----------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_DEFINES_SVH

// same-cycle implication
`define HCBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hcbp assertion failed");

// next-cycle implication
`define HCBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hcbp assertion failed");

`endif

// ===== sv/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Opcodes, code table entry type and fixed code length limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int MAX_CODE_LEN = 8;
    localparam int BYTE_BITS    = 8;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < BYTE_BITS) ? MAX_CODE_LEN : BYTE_BITS;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [7:0] code;
        logic [3:0] len;
    } entry_t;

endpackage

// ===== sv/huffman_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer core
// Code table of symbol codes plus an MSB-first byte packer with flush.
// ----------------------------------------------------------------------------
//  channel  | ports           | carries
//  ---------+-----------------+-------------------------------------------
//  input    | s_valid/s_ready | opcode, symbol, code_bits, code_length
//  result   | m_valid/m_ready | packed_byte, pad_bits, is_final
//
//  One item accepted per cycle while the merge stage is not stalled; an
//  encode or flush item and its registered table read enter the merge
//  stage at acceptance, and a byte it produces goes to the output register.
//  Load items finish at acceptance by writing the table.
//  Reset clears control and the accumulator; the code table is not cleared.
//  m_ready low stalls the merge stage only when it has a byte to hand over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "huffman_code_bit_packer_core_defines.svh"

module huffman_code_bit_packer_core #(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_symbol,
    input  logic [7:0] s_code_bits,
    input  logic [3:0] s_code_length,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_packed_byte,
    output logic [3:0] m_pad_bits,
    output logic       m_is_final
);

    localparam int AddrW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    hcbp_pkg::entry_t table_mem [SYMBOL_COUNT];
    hcbp_pkg::entry_t rd_reg;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_flush_reg;
    logic       s1_skip_reg;
    logic [7:0] acc_reg, acc_next;
    logic [3:0] bits_reg, bits_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg;
    logic [3:0] m_pad_reg;
    logic       m_final_reg;

    hcbp_pkg::opcode_t op;
    hcbp_pkg::entry_t  wr_entry;
    logic              accept;
    logic              sym_ok;
    logic [AddrW-1:0]  addr;
    logic [3:0]        load_len;
    logic [7:0]        cur_code;
    logic [3:0]        cur_len;
    logic [15:0]       merged;
    logic [4:0]        total;
    logic              produce;
    logic              out_free;
    logic              s1_fire;

    assign op       = hcbp_pkg::opcode_t'(s_opcode);
    assign accept   = s_valid && s_ready;
    assign sym_ok   = {1'b0, s_symbol} < 9'(SYMBOL_COUNT);
    assign addr     = s_symbol[AddrW-1:0];
    assign load_len = (s_code_length > 4'(hcbp_pkg::LEN_LIMIT))
                    ? 4'(hcbp_pkg::LEN_LIMIT) : s_code_length;
    assign wr_entry = '{code: s_code_bits & ~(8'hFF >> load_len), len: load_len};

    // table write on load, registered read on encode
    always_ff @(posedge aclk) begin
        if (accept && op == hcbp_pkg::OP_LOAD && sym_ok) begin
            table_mem[addr] <= wr_entry;
        end
        if (accept && op == hcbp_pkg::OP_ENCODE) begin
            rd_reg <= table_mem[addr];
        end
    end

    always_comb begin
        cur_code = s1_skip_reg ? 8'h00 : rd_reg.code;
        cur_len  = s1_skip_reg ? 4'd0  : rd_reg.len;
        merged   = {acc_reg, 8'h00} | ({cur_code, 8'h00} >> bits_reg);
        total    = 5'(bits_reg) + 5'(cur_len);
        produce  = s1_flush_reg || (total > 5'd8);
        out_free = !m_valid_reg || m_ready;
        s1_fire  = s1_valid_reg && (!produce || out_free);
    end

    assign s_ready = !s1_valid_reg || s1_fire;

    always_comb begin
        acc_next      = acc_reg;
        bits_next     = bits_reg;
        s1_valid_next = s1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (s1_fire) begin
            s1_valid_next = 1'b0;
            if (s1_flush_reg) begin
                acc_next  = 8'h00;
                bits_next = 4'd0;
            end else if (total > 5'd8) begin
                acc_next  = merged[7:0];
                bits_next = 4'(total - 5'd8);
            end else begin
                acc_next  = merged[15:8];
                bits_next = total[3:0];
            end
        end
        if (accept && (op == hcbp_pkg::OP_ENCODE || op == hcbp_pkg::OP_FLUSH)) begin
            s1_valid_next = 1'b1;
        end
        if (s1_fire && produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            acc_reg      <= 8'h00;
            bits_reg     <= 4'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            acc_reg      <= acc_next;
            bits_reg     <= bits_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload: hold item info and result data without reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_flush_reg <= (op == hcbp_pkg::OP_FLUSH);
            s1_skip_reg  <= !sym_ok;
        end
        if (s1_fire && produce) begin
            m_byte_reg  <= s1_flush_reg ? acc_reg : merged[15:8];
            m_pad_reg   <= s1_flush_reg ? 4'(4'd8 - bits_reg) : 4'd0;
            m_final_reg <= s1_flush_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packed_byte = m_byte_reg;
    assign m_pad_bits    = m_pad_reg;
    assign m_is_final    = m_final_reg;

    `HCBP_ASSERT_NOW(a_bits_range, 1'b1, bits_reg <= 4'd8)
    `HCBP_ASSERT_NEXT(a_flush_clears, s1_fire && s1_flush_reg, acc_reg == 8'h00 && bits_reg == 4'd0)
    `HCBP_ASSERT_NEXT(a_result_loaded, s1_fire && produce, m_valid_reg)
    `HCBP_ASSERT_NOW(a_plain_no_pad, m_valid_reg && !m_final_reg, m_pad_reg == 4'd0)
    `HCBP_ASSERT_NEXT(a_stage_hold, s1_valid_reg && !s1_fire, s1_valid_reg)

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Loads code table entries, encodes loaded symbols and flushes, checking each
// packed byte, pad count and final flag against an in-order byte packer model.
// Sender and receiver idle at random in the first two of three phases, with one long receiver stall in the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int         CLK_PERIOD  = 20;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RANDOM_PER_PHASE = 240;
    localparam int         LONG_HOLD   = 300;

    typedef struct {
        logic [1:0] opcode;
        logic [7:0] symbol;
        logic [7:0] code_bits;
        logic [3:0] code_length;
        int         phase;
    } symbol_item_t;

    typedef struct {
        logic [7:0] packed_byte;
        logic [3:0] pad_bits;
        logic       is_final;
    } packed_result_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_opcode      = 2'd0;
    logic [7:0] s_symbol      = 8'd0;
    logic [7:0] s_code_bits   = 8'd0;
    logic [3:0] s_code_length = 4'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_packed_byte;
    logic [3:0] m_pad_bits;
    logic       m_is_final;

    symbol_item_t   symbol_items[$];
    packed_result_t packed_bytes_due[$];

    hcbp_pkg::entry_t code_table_copy[256];
    bit               entry_loaded[256];
    logic [7:0]       symbols_loaded[$];
    logic [7:0]       acc_byte = 8'd0;
    int               acc_fill = 0;

    int errors           = 0;
    int cycles           = 0;
    int cur_phase        = 0;
    int recv_hold_cycles = 0;
    bit recv_hold_done   = 1'b0;

    huffman_code_bit_packer_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_symbol      (s_symbol),
        .s_code_bits   (s_code_bits),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_pad_bits    (m_pad_bits),
        .m_is_final    (m_is_final)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int idle_pct(input int phase, input bit sender);
        if (phase == 0) return sender ? 10 : 65;
        if (phase == 1) return sender ? 65 : 10;
        return 0;
    endfunction

    // byte packer model: update table, accumulator and fill for one transfer
    task automatic pack_symbol_item(input logic [1:0] op, input logic [7:0] sym,
                                    input logic [7:0] bits, input logic [3:0] len);
        logic [15:0]      wide_mask;
        logic [3:0]       clamped;
        hcbp_pkg::entry_t entry;
        packed_result_t   res;
        bit               made;
        int               j;
        made = 1'b0;
        case (op)
            hcbp_pkg::OP_LOAD: begin
                clamped = (len > hcbp_pkg::LEN_LIMIT) ? 4'(hcbp_pkg::LEN_LIMIT) : len;
                wide_mask = 16'hFF00 >> clamped;
                code_table_copy[sym].code = bits & wide_mask[7:0];
                code_table_copy[sym].len  = clamped;
            end
            hcbp_pkg::OP_ENCODE: begin
                entry = code_table_copy[sym];
                for (j = 0; j < int'(entry.len) && j < 8; j++) begin
                    if (acc_fill >= 8) begin
                        if (!made) begin
                            res.packed_byte = acc_byte;
                            res.pad_bits    = 4'd0;
                            res.is_final    = 1'b0;
                            packed_bytes_due.push_back(res);
                            made = 1'b1;
                        end
                        acc_byte = 8'd0;
                        acc_fill = 0;
                    end
                    if (entry.code[7 - j]) acc_byte[7 - acc_fill] = 1'b1;
                    acc_fill++;
                end
            end
            hcbp_pkg::OP_FLUSH: begin
                res.packed_byte = acc_byte;
                res.pad_bits    = 4'(8 - acc_fill);
                res.is_final    = 1'b1;
                packed_bytes_due.push_back(res);
                acc_byte = 8'd0;
                acc_fill = 0;
            end
            default: ;
        endcase
    endtask

    task automatic add_item(input logic [1:0] op, input logic [7:0] sym,
                            input logic [7:0] bits, input logic [3:0] len,
                            input int phase);
        symbol_item_t it;
        it.opcode      = op;
        it.symbol      = sym;
        it.code_bits   = bits;
        it.code_length = len;
        it.phase       = phase;
        symbol_items.push_back(it);
        if (op == hcbp_pkg::OP_LOAD && !entry_loaded[sym]) begin
            entry_loaded[sym] = 1'b1;
            symbols_loaded.push_back(sym);
        end
    endtask

    task automatic add_random_item(input int phase);
        int         pick;
        logic [3:0] len;
        logic [7:0] sym;
        pick = $urandom_range(0, 99);
        if (pick < 15 || symbols_loaded.size() == 0) begin
            len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            add_item(hcbp_pkg::OP_LOAD, 8'($urandom), 8'($urandom), len, phase);
        end else if (pick < 90) begin
            sym = symbols_loaded[$urandom_range(0, symbols_loaded.size() - 1)];
            add_item(hcbp_pkg::OP_ENCODE, sym, 8'($urandom), 4'($urandom), phase);
        end else if (pick < 98) begin
            add_item(hcbp_pkg::OP_FLUSH, 8'($urandom), 8'($urandom), 4'($urandom), phase);
        end else begin
            add_item(OP_RESERVED, 8'($urandom), 8'($urandom), 4'($urandom), phase);
        end
    endtask

    always @(posedge aclk) begin : drive
        symbol_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (symbol_items.size() > 0 &&
                $urandom_range(0, 99) >= idle_pct(symbol_items[0].phase, 1'b1)) begin
                it = symbol_items.pop_front();
                s_valid       <= 1'b1;
                s_opcode      <= it.opcode;
                s_symbol      <= it.symbol;
                s_code_bits   <= it.code_bits;
                s_code_length <= it.code_length;
                cur_phase     <= it.phase;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // hold off the result channel once for a long stretch in the last phase
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            m_ready          <= 1'b0;
        end else if (cur_phase == 2 && !recv_hold_done) begin
            recv_hold_cycles <= LONG_HOLD;
            recv_hold_done   <= 1'b1;
            m_ready          <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= idle_pct(cur_phase, 1'b0));
        end
    end

    always @(posedge aclk) begin : monitor
        packed_result_t due;
        if (aresetn) begin
            if (s_valid && s_ready)
                pack_symbol_item(s_opcode, s_symbol, s_code_bits, s_code_length);
            if (m_valid && m_ready) begin
                if (packed_bytes_due.size() == 0) begin
                    $display("%0t: unexpected result byte %02h pad %0d final %0b",
                             $time, m_packed_byte, m_pad_bits, m_is_final);
                    errors++;
                end else begin
                    due = packed_bytes_due.pop_front();
                    if (m_packed_byte !== due.packed_byte) begin
                        $display("%0t: packed_byte expected %02h actual %02h",
                                 $time, due.packed_byte, m_packed_byte);
                        errors++;
                    end
                    if (m_pad_bits !== due.pad_bits) begin
                        $display("%0t: pad_bits expected %0d actual %0d",
                                 $time, due.pad_bits, m_pad_bits);
                        errors++;
                    end
                    if (m_is_final !== due.is_final) begin
                        $display("%0t: is_final expected %0b actual %0b",
                                 $time, due.is_final, m_is_final);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        int p;
        int n;
        for (n = 0; n < 256; n++) begin
            code_table_copy[n] = '0;
            entry_loaded[n]    = 1'b0;
        end

        // zero length, full length, long code clamp, dropped trailing bits
        add_item(hcbp_pkg::OP_LOAD, 8'h00, 8'hFF, 4'd0, 0);
        add_item(hcbp_pkg::OP_LOAD, 8'hFF, 8'hFF, 4'd8, 0);
        add_item(hcbp_pkg::OP_LOAD, 8'h01, 8'hA5, 4'd15, 0);
        add_item(hcbp_pkg::OP_LOAD, 8'h02, 8'hFF, 4'd3, 0);
        add_item(hcbp_pkg::OP_LOAD, 8'h03, 8'h80, 4'd1, 0);
        add_item(hcbp_pkg::OP_FLUSH, 8'h00, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'hFF, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_FLUSH, 8'hFF, 8'hFF, 4'd15, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'hFF, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'h03, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_FLUSH, 8'h00, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'h00, 8'h00, 4'd0, 0);
        add_item(OP_RESERVED, 8'hFF, 8'hFF, 4'd15, 0);
        add_item(hcbp_pkg::OP_LOAD, 8'h02, 8'h55, 4'd7, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'h02, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'h01, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'h02, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'h03, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_LOAD, 8'h80, 8'h00, 4'd8, 0);
        add_item(hcbp_pkg::OP_ENCODE, 8'h80, 8'h00, 4'd0, 0);
        add_item(hcbp_pkg::OP_FLUSH, 8'h00, 8'h00, 4'd0, 0);

        for (p = 0; p < 3; p++)
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                add_random_item(p);
        add_item(hcbp_pkg::OP_FLUSH, 8'h00, 8'h00, 4'd0, 2);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (symbol_items.size() != 0 || s_valid) @(posedge aclk);
        while (packed_bytes_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (errors == 0 && packed_bytes_due.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
